[sv/status_led_pattern_sequencer_top_defines.svh]
// Assertion macros for the status LED sequencer RTL.
`ifndef STATUS_LED_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define STATUS_LED_PATTERN_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that an expression holds at every clock edge outside reset.
`define SLPS_ASSERT_ALWAYS(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("invariant violated");
// Check that a condition in one cycle is followed by another in the next.
`define SLPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sequence violated");
`else
`define SLPS_ASSERT_ALWAYS(label, clk, rstn, expr)
`define SLPS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[sv/slps_pkg.sv]
`default_nettype none

package slps_pkg;

  // One tick transaction as it travels through the block
  typedef struct packed {
    logic [7:0] satellites;
    logic [2:0] gps_state;
    logic       arm_ready;
    logic       armed;
    logic       battery_low;
    logic       init_done;
    logic       motor_cal;
    logic       trim_saving;
    logic       initialising;
  } slps_item_t;

  // LED levels, LED A in the lowest bit
  typedef struct packed {
    logic c;
    logic b;
    logic a;
  } slps_leds_t;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  localparam logic [7:0] TickLast        = 8'hFF;
  localparam logic [1:0] PhaseLast       = 2'd2;
  localparam logic [7:0] InitBlinkThresh = 8'd1;
  localparam logic [7:0] BattBlinkThresh = 8'd10;
  localparam logic [7:0] GpsDivThresh    = 8'd1;
  localparam logic [7:0] MinSatellites   = 8'd6;
  localparam logic [7:0] SatBlinkMin     = 8'd12;

  // GPS state codes
  localparam logic [2:0] GpsNoFix  = 3'd2;
  localparam logic [2:0] GpsLocked = 3'd3;

  // Chase positions
  localparam logic [7:0] ChaseStepA = 8'd0;
  localparam logic [7:0] ChaseStepB = 8'd1;
  localparam logic [7:0] ChaseStepC = 8'd2;
  localparam logic [7:0] ChasePark  = 8'hFF;

endpackage

`default_nettype wire

[sv/status_led_pattern_sequencer_top.sv]
// Status LED pattern sequencer.
// An accepted tick transaction is held in the input register, and its result
// in the result register.
// Throughput: one tick per cycle while the output side takes results.
// Reset (rst_ni low, asynchronous): counters, dividers and core LED state cleared.
`default_nettype none

module status_led_pattern_sequencer_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [0] initialising, [1] trim_saving, [2] motor_cal, [3] init_done,
  // [4] battery_low, [5] armed, [6] arm_ready, [9:7] gps_state,
  // [17:10] satellites, [23:18] zero
  input  wire [slps_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  // [0] led_a, [1] led_b, [2] led_c, [7:3] zero
  output logic [slps_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import slps_pkg::*;

  slps_item_t in_item;
  slps_item_t held_item;
  slps_leds_t next_leds;
  slps_leds_t out_leds;
  logic       held_valid;
  logic       out_free;
  logic       advance;

  // Unpack the input transaction
  always_comb begin
    in_item.initialising    = s_axis_tdata_i[0];
    in_item.trim_saving     = s_axis_tdata_i[1];
    in_item.motor_cal       = s_axis_tdata_i[2];
    in_item.init_done       = s_axis_tdata_i[3];
    in_item.battery_low     = s_axis_tdata_i[4];
    in_item.armed           = s_axis_tdata_i[5];
    in_item.arm_ready       = s_axis_tdata_i[6];
    in_item.gps_state       = s_axis_tdata_i[9:7];
    in_item.satellites      = s_axis_tdata_i[17:10];
  end

  // Move the held tick through the sequencer when the result register has room
  assign advance = held_valid && out_free;

  slps_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  slps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (held_item),
    .leds_o (next_leds)
  );

  slps_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .leds_i  (next_leds),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .leds_o  (out_leds)
  );

  // Pack the result transaction
  assign m_axis_tdata_o = {(OutDataW - 3)'(0), out_leds.c, out_leds.b, out_leds.a};

endmodule

`default_nettype wire

[sv/slps_in_stage.sv]
`default_nettype none

module slps_in_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  slps_pkg::slps_item_t item_i,
  input  wire                 advance_i,
  output logic                valid_o,
  output slps_pkg::slps_item_t item_o
);
  import slps_pkg::*;

  logic       valid_q, valid_d;
  slps_item_t item_q;

  // Take a new transaction when empty or when the held one moves on
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until it is consumed
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[sv/slps_core.sv]
`default_nettype none
`include "status_led_pattern_sequencer_top_defines.svh"

module slps_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  slps_pkg::slps_item_t item_i,
  output slps_pkg::slps_leds_t leds_o
);
  import slps_pkg::*;

  logic [7:0] tick_q, tick_d;
  logic [1:0] mod3_q, mod3_d;
  logic [6:0] slow_q, slow_d;
  logic [7:0] blink_div_q, blink_div_d;
  logic       phase_q, phase_d;
  logic [7:0] chase_q, chase_d;
  logic [7:0] gps_div_q, gps_div_d;
  logic [7:0] sat_cnt_q, sat_cnt_d;
  slps_leds_t leds_q, leds_d;

  logic       acting;
  logic [7:0] blink_thresh;
  logic [7:0] chase_inc;
  logic [7:0] sat_inc;
  logic [7:0] sat_next;

  // Advance the tick counter with its residue and quotient by three
  always_comb begin
    tick_d = tick_q + 8'd1;
    if (tick_q == TickLast) begin
      mod3_d = 2'd0;
      slow_d = 7'd0;
    end else if (mod3_q == PhaseLast) begin
      mod3_d = 2'd0;
      slow_d = slow_q + 7'd1;
    end else begin
      mod3_d = mod3_q + 2'd1;
      slow_d = slow_q;
    end
    acting = (mod3_d == 2'd0);
  end

  // Mode selection on acting ticks
  always_comb begin
    blink_div_d  = blink_div_q;
    phase_d      = phase_q;
    chase_d      = chase_q;
    gps_div_d    = gps_div_q;
    sat_cnt_d    = sat_cnt_q;
    leds_d       = leds_q;
    blink_thresh = item_i.initialising ? InitBlinkThresh : BattBlinkThresh;
    chase_inc    = slow_d[1] ? chase_q : chase_q + 8'd1;
    sat_inc      = sat_cnt_q + 8'd1;
    sat_next     = ({1'b0, sat_inc} > {item_i.satellites, 1'b0}) ? 8'd0 : sat_inc;

    if (acting) begin
      if (item_i.initialising) begin
        blink_div_d = blink_div_q + 8'd1;
        if (blink_div_q > blink_thresh) begin
          blink_div_d = 8'd0;
          leds_d.a    = phase_q;
          phase_d     = !phase_q;
        end
      end else if (item_i.trim_saving || item_i.motor_cal) begin
        chase_d = chase_inc;
        case (chase_inc)
          ChaseStepA: begin
            leds_d.c = 1'b0;
            leds_d.a = 1'b1;
          end
          ChaseStepB: begin
            leds_d.a = 1'b0;
            leds_d.b = 1'b1;
          end
          ChaseStepC: begin
            leds_d.b = 1'b0;
            leds_d.c = 1'b1;
          end
          default: chase_d = ChasePark;
        endcase
      end else begin
        // LED A by priority
        if (!item_i.init_done) begin
          leds_d.a = phase_q;
          phase_d  = !phase_q;
        end else if (item_i.battery_low) begin
          blink_div_d = blink_div_q + 8'd1;
          if (blink_div_q > blink_thresh) begin
            blink_div_d = 8'd0;
            leds_d.a    = phase_q;
            phase_d     = !phase_q;
          end
        end else if (item_i.armed) begin
          leds_d.a = 1'b1;
        end else if (item_i.arm_ready) begin
          leds_d.a = !leds_q.a;
        end else begin
          leds_d.a = 1'b0;
        end

        // LED C from the GPS state
        if (item_i.gps_state <= GpsNoFix) begin
          leds_d.c = 1'b0;
        end else if (item_i.gps_state == GpsLocked) begin
          gps_div_d = gps_div_q + 8'd1;
          if (gps_div_q > GpsDivThresh) begin
            gps_div_d = 8'd0;
            if (item_i.satellites >= MinSatellites) begin
              sat_cnt_d = sat_next;
              leds_d.c  = (sat_next >= SatBlinkMin) && !sat_next[0];
            end else begin
              leds_d.c = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= 8'd0;
      mod3_q      <= 2'd0;
      slow_q      <= 7'd0;
      blink_div_q <= 8'd0;
      phase_q     <= 1'b0;
      chase_q     <= 8'd0;
      gps_div_q   <= 8'd0;
      sat_cnt_q   <= 8'd0;
      leds_q      <= '0;
    end else if (step_i) begin
      tick_q      <= tick_d;
      mod3_q      <= mod3_d;
      slow_q      <= slow_d;
      blink_div_q <= blink_div_d;
      phase_q     <= phase_d;
      chase_q     <= chase_d;
      gps_div_q   <= gps_div_d;
      sat_cnt_q   <= sat_cnt_d;
      leds_q      <= leds_d;
    end
  end

  assign leds_o = leds_d;

  // Residue and quotient stay in step with the tick counter
  `SLPS_ASSERT_ALWAYS(a_tick_split, clk_i, rst_ni, (9'(slow_q) * 9'd3 + 9'(mod3_q)) == 9'(tick_q))
  // Chase position only ever rests on a lit step or parked
  `SLPS_ASSERT_ALWAYS(a_chase_range, clk_i, rst_ni, (chase_q <= ChaseStepC) || (chase_q == ChasePark))
  // Non-acting ticks leave the LEDs alone
  `SLPS_ASSERT_NEXT(a_idle_tick, clk_i, rst_ni, step_i && !acting, leds_q == $past(leds_q))

endmodule

`default_nettype wire

[sv/slps_out_stage.sv]
`default_nettype none

module slps_out_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  slps_pkg::slps_leds_t leds_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  wire                  ready_i,
  output slps_pkg::slps_leds_t leds_o
);
  import slps_pkg::*;

  logic       valid_q, valid_d;
  slps_leds_t leds_q;

  // Room for a new result when empty or when the held one is taken now
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      leds_q <= leds_i;
    end
  end

  assign valid_o = valid_q;
  assign leds_o  = leds_q;

endmodule

`default_nettype wire

[dv/status_led_pattern_sequencer_top_test.sv]
module status_led_pattern_sequencer_top_test;
  import slps_pkg::*;

  localparam int unsigned TicksPerStep  = 3;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned PhaseTicks    = 600;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned TimeoutCycles = 500000;

  // Which flag decides LED A on an acting tick
  typedef enum int unsigned {
    ModeInit, ModeChase, ModeNoInit, ModeBattery, ModeArmed, ModeArmReady, ModeIdle
  } led_mode_e;

  // Predict LED levels per tick and compare them with the result stream
  class led_scoreboard;
    logic [7:0] tick_count  = '0;
    logic [7:0] blink_div   = '0;
    logic       blink_phase = 1'b0;
    logic [7:0] chase_pos   = '0;
    logic [7:0] gps_div     = '0;
    logic [7:0] sat_blink   = '0;
    slps_leds_t leds        = '0;
    slps_leds_t led_queue[$];
    int unsigned mismatches = 0;
    int unsigned results    = 0;

    // Copy the blink phase onto LED A, then invert it
    function void take_phase();
      leds.a      = blink_phase;
      blink_phase = ~blink_phase;
    endfunction

    function void divided_blink(logic [7:0] thresh);
      logic [7:0] prev;
      prev      = blink_div;
      blink_div = blink_div + 8'd1;
      if (prev > thresh) begin
        blink_div = '0;
        take_phase();
      end
    endfunction

    // Work out the LED levels after one accepted tick transaction
    function void note_tick(slps_item_t it);
      logic [7:0] slow;
      logic [7:0] prev;
      tick_count = tick_count + 8'd1;
      if (tick_count % TicksPerStep == 0) begin
        slow = 8'(tick_count / TicksPerStep);
        if (it.initialising) begin
          divided_blink(InitBlinkThresh);
        end else if (it.trim_saving || it.motor_cal) begin
          // advance the chase on the first two steps of every four
          if (!slow[1]) chase_pos = chase_pos + 8'd1;
          case (chase_pos)
            ChaseStepA: begin
              leds.c = 1'b0;
              leds.a = 1'b1;
            end
            ChaseStepB: begin
              leds.a = 1'b0;
              leds.b = 1'b1;
            end
            ChaseStepC: begin
              leds.b = 1'b0;
              leds.c = 1'b1;
            end
            default: chase_pos = ChasePark;
          endcase
        end else begin
          if (!it.init_done) take_phase();
          else if (it.battery_low) divided_blink(BattBlinkThresh);
          else if (it.armed) leds.a = 1'b1;
          else if (it.arm_ready) leds.a = ~leds.a;
          else leds.a = 1'b0;

          // LED C follows the GPS state
          if (it.gps_state <= GpsNoFix) begin
            leds.c = 1'b0;
          end else if (it.gps_state == GpsLocked) begin
            prev    = gps_div;
            gps_div = gps_div + 8'd1;
            if (prev > GpsDivThresh) begin
              gps_div = '0;
              if (it.satellites >= MinSatellites) begin
                sat_blink = sat_blink + 8'd1;
                if ({1'b0, sat_blink} > {it.satellites, 1'b0}) sat_blink = '0;
                leds.c = (sat_blink >= SatBlinkMin) && !sat_blink[0];
              end else begin
                leds.c = 1'b0;
              end
            end
          end
        end
      end
      led_queue.push_back(leds);
    endfunction

    function void flag_error(string msg);
      mismatches++;
      if (mismatches <= ReportLimit) $display("%s", msg);
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_leds(logic [OutDataW-1:0] tdata);
      slps_leds_t want;
      slps_leds_t got;
      results++;
      if (led_queue.size() == 0) begin
        flag_error($sformatf("result %0d arrived with none pending: tdata=%h",
                             results, tdata));
        return;
      end
      want = led_queue.pop_front();
      got  = tdata[2:0];
      if (got.a !== want.a || got.b !== want.b || got.c !== want.c
          || tdata[OutDataW-1:3] !== '0)
        flag_error($sformatf("result %0d: expected a=%b b=%b c=%b, got a=%b b=%b c=%b pad=%b",
                             results, want.a, want.b, want.c, got.a, got.b, got.c,
                             tdata[OutDataW-1:3]));
    endfunction
  endclass

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                m_tready = 1'b0;
  wire                 s_axis_tready_o;
  wire                 m_axis_tvalid_o;
  wire [OutDataW-1:0]  m_axis_tdata_o;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  led_scoreboard sb;

  status_led_pattern_sequencer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Take results and stall the output side at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_tready) sb.check_leds(m_axis_tdata_o);
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Build a tick whose flags select the given mode, lower-priority flags random
  function automatic slps_item_t build_tick(led_mode_e mode, logic [2:0] gps,
                                            logic [7:0] sats);
    slps_item_t it;
    logic [31:0] word;
    word = $urandom;
    it   = word[17:0];
    it.gps_state  = gps;
    it.satellites = sats;
    if (mode != ModeInit) it.initialising = 1'b0;
    case (mode)
      ModeInit: it.initialising = 1'b1;
      ModeChase: if (!it.trim_saving) it.motor_cal = 1'b1;
      default: begin
        it.trim_saving = 1'b0;
        it.motor_cal   = 1'b0;
        it.init_done   = (mode != ModeNoInit);
        if (mode > ModeNoInit) it.battery_low = (mode == ModeBattery);
        if (mode > ModeBattery) it.armed = (mode == ModeArmed);
        if (mode > ModeArmed) it.arm_ready = (mode == ModeArmReady);
      end
    endcase
    return it;
  endfunction

  // Offer one tick transaction, idling first at random, and hold until taken
  task automatic send_tick(slps_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW - 18){1'b0}}, it};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_tick(it);
  endtask

  // Hold off the input side until every pending result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.led_queue.size() != 0) @(posedge clk_i);
  endtask

  // Mostly held modes with random content, some noise ticks in between
  task automatic run_phase(int unsigned n_ticks);
    int unsigned sent;
    int unsigned seg_len;
    int unsigned pick;
    led_mode_e   mode;
    logic [2:0]  gps;
    logic [7:0]  sats;
    logic [31:0] word;
    sent = 0;
    while (sent < n_ticks) begin
      mode    = led_mode_e'($urandom_range(ModeIdle));
      seg_len = $urandom_range(6, 120);
      gps     = ($urandom_range(99) < 60) ? GpsLocked : 3'($urandom_range(7));
      pick    = $urandom_range(99);
      if (pick < 70) sats = 8'($urandom_range(6, 24));
      else if (pick < 85) sats = 8'($urandom_range(5));
      else sats = 8'($urandom_range(255));
      for (int unsigned i = 0; i < seg_len && sent < n_ticks; i++) begin
        if ($urandom_range(99) < 8) begin
          word = $urandom;
          send_tick(slps_item_t'(word[17:0]));
        end else begin
          send_tick(build_tick(mode, gps, sats));
        end
        sent++;
      end
    end
  endtask

  // Main sequence: reset, directed ticks, then three phases of random traffic
  initial begin
    logic [7:0] edge_sats [3];
    sb = new;
    edge_sats[0] = 8'd0;
    edge_sats[1] = 8'd255;
    edge_sats[2] = MinSatellites;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, then every mode over three ticks, one of them acting
    send_tick('0);
    send_tick('1);
    for (int m = ModeInit; m <= ModeIdle; m++)
      for (int k = 0; k < 3; k++)
        send_tick(build_tick(led_mode_e'(m), 3'((m * 3 + k) % 8), edge_sats[k]));
    drain_results();

    src_idle_pct  = 35;
    sink_idle_pct = 82;
    run_phase(PhaseTicks);
    drain_results();

    src_idle_pct  = 82;
    sink_idle_pct = 35;
    run_phase(PhaseTicks);
    drain_results();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_phase(PhaseTicks);

    // wait out every pending result plus the pipeline latency
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.led_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TimeoutCycles * 10);
    $display("Regression FAIL");
    $finish;
  end

endmodule
